// ----- rtl/gpf_pkg.sv -----
// package for the goldbach pair finder
// shared types and constants, no dependencies
package gpf_pkg;

    // front-to-back job descriptor
    typedef struct packed {
        logic        none;   // no pair possible, answer zeros
        logic        odd;    // odd target, only p = 2 is tried
        logic [31:0] value;  // target reduced to value width
    } gpf_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST_P,
        ST_TEST_Q,
        ST_DIV,
        ST_NEXT,
        ST_DONE
    } gpf_state_t;

endpackage

// ----- rtl/gpf_divider.sv -----
// restoring radix-2 remainder unit, one quotient bit per cycle
// depends on nothing but its parameter
module gpf_divider #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic         zero_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  num_reg, num_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], num_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[W-2:0], 1'b0};
            rem_next = diff[W] ? shifted : diff;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign zero_rem = (rem_reg == '0);
endmodule

// ----- rtl/gpf_front.sv -----
// front end: takes targets and classifies them into job descriptors
// depends on gpf_pkg
module gpf_front #(
    parameter int W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       target,
    output logic              q_valid,
    input  logic              q_stall,
    output gpf_pkg::gpf_job_t q_job
);
    import gpf_pkg::*;

    // two-entry queue toward the back end
    gpf_job_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    logic [31:0] val;
    gpf_job_t   job;

    // target reduced to its low W bits
    always_comb
    begin
        val = 32'(target) & (32'hFFFF_FFFF >> (32 - W));
        job.value = val;
        job.none  = (val < 32'd4);
        job.odd   = val[0];
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && !q_stall;
    assign q_job    = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= job;
    end
endmodule

// ----- rtl/gpf_back.sv -----
// back end: searches primes p ascending by trial division, holds result
// depends on gpf_pkg and gpf_divider
module gpf_back #(
    parameter int W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_stall,
    input  gpf_pkg::gpf_job_t q_job,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [15:0]       first_prime,
    output logic [15:0]       second_prime
);
    import gpf_pkg::*;

    gpf_state_t   state_reg, state_next;
    logic [W-1:0] tgt_reg, p_reg, n_reg, d_reg;
    logic         odd_reg, testq_reg;
    logic         ov_reg, hit_reg;
    logic [W-1:0] fp_reg, sp_reg;
    logic         div_start, div_done, div_zero;
    logic [2*W-1:0] dsq;
    logic         take, n_small, sq_over, cand_prime;
    logic [W-1:0] q_val;

    assign q_val = q_job.value[W-1:0];

    gpf_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(n_reg), .divisor(d_reg),
        .done(div_done), .zero_rem(div_zero)
    );

    // d*d > n ends trial division with a prime verdict
    assign dsq     = d_reg * d_reg;
    assign sq_over = dsq > {{W{1'b0}}, n_reg};
    assign n_small = n_reg < W'(2);
    assign take    = (state_reg == ST_IDLE) && q_valid && !ov_reg;
    assign q_stall = !((state_reg == ST_IDLE) && !ov_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (take) state_next = q_job.none ? ST_DONE : ST_TEST_P;
            ST_TEST_P: state_next = ST_DIV;
            ST_TEST_Q: state_next = ST_DIV;
            ST_DIV:
                if (n_small)
                    state_next = ST_NEXT;
                else if (sq_over)
                    state_next = testq_reg ? ST_DONE : ST_TEST_Q;
                else if (div_done)
                    state_next = div_zero ? ST_NEXT : ST_DIV;
            ST_NEXT:
                state_next = (odd_reg || (p_reg >= (tgt_reg >> 1))) ? ST_DONE : ST_TEST_P;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // divider kick: first trial and each following divisor
    logic busy_div_reg;
    assign div_start = (state_reg == ST_DIV) && !n_small && !sq_over && !busy_div_reg;
    assign cand_prime = (state_reg == ST_DIV) && !n_small && sq_over && testq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ov_reg       <= 1'b0;
            busy_div_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
                busy_div_reg <= 1'b1;
            else if (div_done || state_reg != ST_DIV)
                busy_div_reg <= 1'b0;
            if (state_reg == ST_DONE)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    tgt_reg <= q_val;
                    odd_reg <= q_job.odd;
                    p_reg   <= W'(2);
                    hit_reg <= 1'b0;
                end
            ST_TEST_P:
            begin
                n_reg     <= p_reg;
                d_reg     <= W'(2);
                testq_reg <= 1'b0;
            end
            ST_TEST_Q:
            begin
                n_reg     <= tgt_reg - p_reg;
                d_reg     <= W'(2);
                testq_reg <= 1'b1;
            end
            ST_DIV:
            begin
                if (div_done && !div_zero)
                    d_reg <= d_reg + 1'b1;
                if (cand_prime)
                    hit_reg <= 1'b1;
            end
            ST_NEXT:   p_reg <= p_reg + 1'b1;
            ST_DONE:
            begin
                fp_reg <= hit_reg ? p_reg : '0;
                sp_reg <= hit_reg ? tgt_reg - p_reg : '0;
            end
            default: ;
        endcase
    end

    assign out_valid    = ov_reg;
    assign found        = hit_reg;
    assign first_prime  = 16'(fp_reg);
    assign second_prime = 16'(sp_reg);
endmodule

// ----- rtl/goldbach_pair_finder.sv -----
// search: targets below 4 skip it; otherwise each trial divisor takes one
// pass of the remainder unit, over all primality tests of the ascending search
// throughput: one transaction at a time in the search, set by the shared
// radix-2 remainder unit; a two-entry queue lets targets enter meanwhile
// reset: rst_n asynchronous active low clears queue, fsm and output valid
module goldbach_pair_finder #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] first_prime,
    output logic [15:0] second_prime
);
    import gpf_pkg::*;

    // queue between classification and search
    logic     q_valid, q_stall;
    gpf_job_t q_job;

    gpf_front #(.W(VALUE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .target(target),
        .q_valid(q_valid), .q_stall(q_stall), .q_job(q_job)
    );

    // search engine with output register
    gpf_back #(.W(VALUE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_job(q_job),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .first_prime(first_prime), .second_prime(second_prime)
    );
endmodule

// ----- rtl/gpf_checker.sv -----
// port-level checks for the goldbach pair finder
// depends on goldbach_pair_finder, attached by bind
module gpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [15:0] first_prime,
    input logic [15:0] second_prime
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_prime))
        else $error("result dropped while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> first_prime == 16'd0 && second_prime == 16'd0)
        else $error("miss result not zero");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> first_prime <= second_prime && first_prime >= 16'd2)
        else $error("pair out of order");
endmodule

bind goldbach_pair_finder gpf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .first_prime(first_prime), .second_prime(second_prime)
);

// ----- tb/goldbach_pair_checker.sv -----
// checker for the goldbach pair finder: watches both channels, predicts each
// result from the accepted target and compares found and both primes; no dependencies
module goldbach_pair_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] target,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        found,
    input  logic [15:0] first_prime,
    input  logic [15:0] second_prime,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        found;
        logic [15:0] first_prime;
        logic [15:0] second_prime;
    } pair_t;

    pair_t expected_pairs[$];

    function automatic bit trial_prime(input int unsigned n);
        int unsigned d;
        if (n < 2)
            return 0;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic pair_t split_target(input logic [15:0] t);
        pair_t r;
        int unsigned p;
        r = '0;
        if (t >= 4) begin
            if (t[0]) begin
                if (trial_prime(t - 2)) begin
                    r.found = 1'b1;
                    r.first_prime = 16'd2;
                    r.second_prime = t - 16'd2;
                end
            end else begin
                for (p = 2; p <= t / 2; p++) begin
                    if (trial_prime(p) && trial_prime(t - p)) begin
                        r.found = 1'b1;
                        r.first_prime = p[15:0];
                        r.second_prime = t - p[15:0];
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    assign pending = expected_pairs.size();

    always @(posedge clk or negedge rst_n)
    begin
        pair_t want;
        if (!rst_n) begin
            fail_count <= 0;
            expected_pairs.delete();
        end else begin
            if (in_valid && !in_stall)
                expected_pairs.push_back(split_target(target));
            if (out_valid && !out_stall) begin
                if (expected_pairs.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction: %0d %0d %0d",
                                 found, first_prime, second_prime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_pairs.pop_front();
                    if (want !== {found, first_prime, second_prime}) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.found, want.first_prime, want.second_prime,
                                     found, first_prime, second_prime);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/goldbach_pair_finder_tb.sv -----
// top of the goldbach pair finder testbench: clock, reset, stimulus, verdict
// depends on rtl/goldbach_pair_finder.sv and tb/goldbach_pair_checker.sv
module goldbach_pair_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] target;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [15:0] first_prime;
    logic [15:0] second_prime;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          long_hold;    // receiver long hold-off request
    bit          hold_done;

    goldbach_pair_finder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .target(target),
        .out_valid(out_valid), .out_stall(out_stall), .found(found),
        .first_prime(first_prime), .second_prime(second_prime)
    );

    goldbach_pair_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .target(target),
        .out_valid(out_valid), .out_stall(out_stall), .found(found),
        .first_prime(first_prime), .second_prime(second_prime),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // timeout guard; the search is slow for large even targets
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // keep most searches short: small and mid targets, a few large ones
    function automatic logic [15:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 200));
        if (r < 85)
            return 16'($urandom_range(0, 4095));
        return 16'($urandom);
    endfunction

    // one input transaction, waits for the handshake; valid stays high
    // into a back-to-back transaction
    task automatic send_target(input logic [15:0] t);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        target <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        out_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold && !hold_done) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [15:0] directed[$];
        int i;
        long_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        target = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small targets with no pair, smallest pairs, odd with and without
        // prime target - 2, a prime target, extremes of the field
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
                     16'd9, 16'd11, 16'd13, 16'd27, 16'd97, 16'd100, 16'd128,
                     16'd65535, 16'd65534, 16'd65533, 16'd32768, 16'd65521,
                     16'd21845, 16'd43690};
        foreach (directed[i])
            send_target(directed[i]);
        in_valid <= 1'b0;

        // pause until every result has arrived
        while (pending != 0) @(posedge clk);

        // long receiver hold-off while targets keep coming
        long_hold = 1'b1;
        for (i = 0; i < 20; i++)
            send_target(16'($urandom_range(4, 300)));

        for (i = 0; i < 248; i++)
            send_target(pick_target());
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/gpf_pkg.sv
rtl/gpf_divider.sv
rtl/gpf_front.sv
rtl/gpf_back.sv
rtl/goldbach_pair_finder.sv
rtl/gpf_checker.sv
tb/goldbach_pair_checker.sv
tb/goldbach_pair_finder_tb.sv
